[hw/rtl/slab_point_location_query_core_defines.svh]
// Assertion helpers for the slab point location core
`ifndef SLAB_POINT_LOCATION_QUERY_CORE_DEFINES_SVH
`define SLAB_POINT_LOCATION_QUERY_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define SLPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slpq check failed");

// next-cycle implication, held off during reset
`define SLPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slpq check failed");

`endif

[hw/rtl/slpq_pkg.sv]
package slpq_pkg;

    localparam int unsigned COORD_BITS       = 16;
    localparam int unsigned SEG_AW           = 10;
    localparam int unsigned COL_AW           = 9;
    localparam int unsigned CELL_AW          = 12;
    localparam int unsigned CNT_W            = 10;
    localparam int unsigned MAX_COLUMNS      = 512;
    localparam int unsigned MAX_CELLS_PER_COL = 64;
    localparam int unsigned IN_DATA_W        = 120;
    localparam int unsigned OUT_DATA_W       = 16;

    typedef enum logic [1:0] {
        ACT_QUERY = 2'd0,
        ACT_SEG   = 2'd1,
        ACT_COL   = 2'd2,
        ACT_CELL  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_LEFT    = 2'd1,
        ST_BELOW   = 2'd2,
        ST_UNUSED  = 2'd3
    } t_status;

endpackage

[hw/rtl/slab_point_location_query_core.sv]
// Loads (segment, column, cell) are taken one per cycle while idle and give no result.
// A query runs a column search (up to 10 steps: S_COL_RD, S_COL_CMP), a cell search
// (up to 7 steps: S_CELL_RD, S_SEG_RD, S_MUL_P, S_MUL_Q, S_CMP), a cell fetch and S_DONE;
// input not ready meanwhile. A result still waiting on m_axis_tready holds the sequencer
// in its last state. One read port per table and the one shared 18x18 multiplier set these steps.
// Sync active-low reset clears sequencer and output, column_count to 1; tables kept.
module slab_point_location_query_core
    import slpq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CNT_W-1:0]      i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry, x_a, y_a, x_b, y_b, first_cell, cell_total, line_ref, region, pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // region_found, pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]            m_axis_tuser
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_COL_RD  = 10'b0000000010,
        S_COL_CMP = 10'b0000000100,
        S_COL_GET = 10'b0000001000,
        S_CELL_RD = 10'b0000010000,
        S_SEG_RD  = 10'b0000100000,
        S_MUL_P   = 10'b0001000000,
        S_MUL_Q   = 10'b0010000000,
        S_CMP     = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } t_state;

    // S_REG_GET folded: final cell read is handled by a flag
    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_col_count;
    logic [CNT_W-1:0]  r_lo, n_lo, r_hi, n_hi;
    logic signed [COORD_BITS-1:0] r_x, r_y;
    logic [CELL_AW-1:0] r_first, n_first;
    logic               r_final, n_final;
    logic [11:0]        r_res_region, n_res_region;
    t_status            r_res_status, n_res_status;
    logic signed [35:0] r_p, r_q;
    logic               r_out_valid;
    logic [11:0]        r_out_region;
    t_status            r_out_status;

    // tables
    logic [63:0] seg_mem  [0:(1<<SEG_AW)-1];
    logic [34:0] col_mem  [0:(1<<COL_AW)-1];
    logic [21:0] cell_mem [0:(1<<CELL_AW)-1];
    logic [63:0] r_seg_q;
    logic [34:0] r_col_q;
    logic [21:0] r_cell_q;
    logic [SEG_AW-1:0]  seg_ra;
    logic [COL_AW-1:0]  col_ra;
    logic [CELL_AW-1:0] cell_ra;

    logic        accept;
    t_action     act;
    logic [11:0] in_entry;
    logic [CNT_W-1:0] n_cols;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid, lo_m1;
    logic [6:0]  cnt_sat;

    // segment fields from registered read data
    logic signed [COORD_BITS-1:0] s_x1, s_y1, s_x2, s_y2;
    logic signed [16:0] dx, dy, xd, yd;
    logic signed [17:0] dxn, dyn, mul_a, mul_b;
    logic signed [35:0] mul_out;
    logic        line_le;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign act      = t_action'(s_axis_tuser);
    assign in_entry = s_axis_tdata[11:0];

    assign n_cols  = (r_col_count > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : r_col_count;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CNT_W:1];
    assign lo_m1   = r_lo - CNT_W'(1);
    assign cnt_sat = (r_col_q[34:28] > 7'(MAX_CELLS_PER_COL)) ? 7'(MAX_CELLS_PER_COL)
                                                              : r_col_q[34:28];

    assign s_x1 = r_seg_q[15:0];
    assign s_y1 = r_seg_q[31:16];
    assign s_x2 = r_seg_q[47:32];
    assign s_y2 = r_seg_q[63:48];
    assign dx   = 17'(s_x2) - 17'(s_x1);
    assign dy   = 17'(s_y2) - 17'(s_y1);
    assign xd   = 17'(r_x) - 17'(s_x1);
    assign yd   = 17'(r_y) - 17'(s_y1);
    assign dxn  = dx[16] ? -18'(dx) : 18'(dx);
    assign dyn  = dx[16] ? -18'(dy) : 18'(dy);

    // shared multiplier: dy*(x-x1) first, then (y-y1)*dx
    assign mul_a   = (r_state == S_MUL_P) ? dyn : 18'(yd);
    assign mul_b   = (r_state == S_MUL_P) ? 18'(xd) : dxn;
    assign mul_out = mul_a * mul_b;
    assign line_le = (dx == 17'sd0) ? (s_y1 <= r_y) : (r_p <= r_q);

    always_comb begin
        n_state      = r_state;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_first      = r_first;
        n_final      = r_final;
        n_res_region = r_res_region;
        n_res_status = r_res_status;
        col_ra       = mid[COL_AW-1:0];
        cell_ra      = r_first + CELL_AW'(mid);
        seg_ra       = r_cell_q[9:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept && act == ACT_QUERY) begin
                    n_lo    = '0;
                    n_hi    = n_cols;
                    n_state = S_COL_RD;
                end
            end
            S_COL_RD: begin
                if (r_lo < r_hi) begin
                    n_state = S_COL_CMP;
                end else if (r_lo == '0) begin
                    n_res_region = '0;
                    n_res_status = ST_LEFT;
                    n_state      = S_DONE;
                end else begin
                    col_ra  = lo_m1[COL_AW-1:0];
                    n_state = S_COL_GET;
                end
            end
            S_COL_CMP: begin
                if (r_x < $signed(r_col_q[15:0])) n_hi = mid;
                else n_lo = mid + CNT_W'(1);
                n_state = S_COL_RD;
            end
            S_COL_GET: begin
                n_first = r_col_q[27:16];
                n_lo    = '0;
                n_hi    = CNT_W'(cnt_sat);
                n_final = 1'b0;
                n_state = S_CELL_RD;
            end
            S_CELL_RD: begin
                if (r_final) begin
                    // last located cell is in the read register
                    n_res_region = r_cell_q[21:10];
                    n_res_status = ST_FOUND;
                    n_state      = S_DONE;
                end else if (r_lo < r_hi) begin
                    n_state = S_SEG_RD;
                end else if (r_lo == '0) begin
                    n_res_region = '0;
                    n_res_status = ST_BELOW;
                    n_state      = S_DONE;
                end else begin
                    cell_ra = r_first + CELL_AW'(lo_m1);
                    n_final = 1'b1;
                end
            end
            S_SEG_RD: n_state = S_MUL_P;
            S_MUL_P:  n_state = S_MUL_Q;
            S_MUL_Q:  n_state = S_CMP;
            S_CMP: begin
                if (line_le) n_lo = mid + CNT_W'(1);
                else n_hi = mid;
                n_state = S_CELL_RD;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // tables: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (accept && act == ACT_SEG && in_entry[11:SEG_AW] == '0)
            seg_mem[in_entry[SEG_AW-1:0]] <= s_axis_tdata[75:12];
        if (accept && act == ACT_COL && in_entry[11:COL_AW] == '0)
            col_mem[in_entry[COL_AW-1:0]] <= {s_axis_tdata[94:76], s_axis_tdata[27:12]};
        if (accept && act == ACT_CELL)
            cell_mem[in_entry] <= {s_axis_tdata[116:105], s_axis_tdata[104:95]};
        r_seg_q  <= seg_mem[seg_ra];
        r_col_q  <= col_mem[col_ra];
        r_cell_q <= cell_mem[cell_ra];
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_first      <= n_first;
        r_res_region <= n_res_region;
        r_res_status <= n_res_status;
        if (accept && act == ACT_QUERY) begin
            r_x <= s_axis_tdata[27:12];
            r_y <= s_axis_tdata[43:28];
        end
        if (r_state == S_MUL_P) r_p <= mul_out;
        if (r_state == S_MUL_Q) r_q <= mul_out;
        if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_region <= r_res_region;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
            r_col_count <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_final <= n_final;
            if (i_cfg_we) r_col_count <= i_cfg_data;
            if (r_state == S_DONE && (!r_out_valid || m_axis_tready))
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_region};
    assign m_axis_tuser  = r_out_status;

endmodule

[hw/rtl/slpq_checker.sv]
`include "slab_point_location_query_core_defines.svh"
module slpq_checker
    import slpq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [1:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser
);

    // stalled result holds
    `SLPQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // a miss carries region zero
    `SLPQ_ASSERT_NOW(a_miss_zero, m_axis_tvalid && m_axis_tuser != ST_FOUND, m_axis_tdata == '0)
    // status code never the spare value
    `SLPQ_ASSERT_NOW(a_status_ok, m_axis_tvalid, m_axis_tuser != ST_UNUSED)
    // a query transaction makes the block busy
    `SLPQ_ASSERT_NEXT(a_query_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_QUERY, !s_axis_tready)
    // a load transaction leaves it ready
    `SLPQ_ASSERT_NEXT(a_load_ready, s_axis_tvalid && s_axis_tready && s_axis_tuser != ACT_QUERY, s_axis_tready)

endmodule

bind slab_point_location_query_core slpq_checker u_slpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
